// ===== hw/rtl/char_lcd_nibble_sequencer_macros.svh =====
// assertion macros for the character lcd nibble sequencer
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent holds, consequent must hold in the same cycle
`define CLNS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent must hold in the next cycle
`define CLNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CLNS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define CLNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/clns_pkg.sv =====
// types and constants of the character lcd nibble sequencer
// no dependencies; used by the top level and the bench
package clns_pkg;

  localparam int DelayWidth = 20;
  localparam int CfgWidth   = 20;
  localparam int PaddrWidth = 4;
  localparam int ApbWidth   = 32;
  localparam int StepWidth  = 3;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpInit  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    RegPowerUp    = 2'd0,
    RegSecondWait = 2'd1,
    RegThirdWait  = 2'd2,
    RegSettle     = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    PhIdle  = 5'd0,
    PhDelay = 5'd1,
    PhHiSet = 5'd2,
    PhHiEn  = 5'd3,
    PhLoSet = 5'd4,
    PhLoEn  = 5'd5,
    PhBSet  = 5'd6,
    PhBHold = 5'd7,
    PhBDrop = 5'd8,
    PhBEn2  = 5'd9,
    PhBGap  = 5'd10
  } phase_e;

  // init sequence steps, zero means no init running
  localparam logic [StepWidth-1:0] StepNone       = 3'd0;
  localparam logic [StepWidth-1:0] StepPowerUp    = 3'd1;
  localparam logic [StepWidth-1:0] StepSecondWait = 3'd2;
  localparam logic [StepWidth-1:0] StepThirdWait  = 3'd3;
  localparam logic [StepWidth-1:0] StepFourBit    = 3'd4;
  localparam logic [StepWidth-1:0] StepFuncSet    = 3'd5;
  localparam logic [StepWidth-1:0] StepDisplayOn  = 3'd6;

  localparam logic [7:0] WakeNibble  = 8'h03;
  localparam logic [7:0] FourBitNib  = 8'h02;
  localparam logic [7:0] FuncSetCmd  = 8'h28;
  localparam logic [7:0] DispOnCmd   = 8'h0f;

  localparam logic [CfgWidth-1:0] PowerUpReset    = 20'd15000;
  localparam logic [CfgWidth-1:0] SecondWaitReset = 20'd4000;
  localparam logic [CfgWidth-1:0] ThirdWaitReset  = 20'd120;
  localparam logic [CfgWidth-1:0] SettleReset     = 20'd1;

endpackage

// ===== hw/rtl/clns_if.sv =====
// valid/ready channels of the character lcd nibble sequencer
// no dependencies; field widths are written out in place
interface clns_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] value;
  logic       register_select;
  logic       wait_busy;
  logic       busy_line;

  modport source (output valid, op, value, register_select, wait_busy, busy_line,
                  input ready);
  modport sink (input valid, op, value, register_select, wait_busy, busy_line,
                output ready);
endinterface

interface clns_pin_if;
  logic       valid;
  logic       ready;
  logic       rs_pin;
  logic       rw_pin;
  logic       enable_pin;
  logic [3:0] data_nibble;
  logic       drive_bus;
  logic       idle;
  logic       rejected;

  modport source (output valid, rs_pin, rw_pin, enable_pin, data_nibble, drive_bus,
                  idle, rejected, input ready);
  modport sink (input valid, rs_pin, rw_pin, enable_pin, data_nibble, drive_bus,
                idle, rejected, output ready);
endinterface

// ===== hw/rtl/char_lcd_nibble_sequencer.sv =====
// character lcd 4-bit bus sequencer: pin phases, init sequence, busy polling
// depends on clns_pkg, clns_if.sv and char_lcd_nibble_sequencer_macros.svh
//
//  channel   dir  handshake             beat
//  req_i     in   valid/ready           op, value, register_select, wait_busy, busy_line
//  pin_o     out  valid/ready           rs, rw, enable, data_nibble, drive_bus, idle,
//                                       rejected
//  apb       in   psel/penable/pwrite   one 20-bit register per 4-byte word
//
// one beat in, one beat out, one beat per cycle sustained while pin_o is ready
// the phase update and pin decode sit between the state registers and the
// output register, so a beat is offered on pin_o in the cycle after it is taken
// the input is taken whenever the output register is empty or being drained
// reset puts the sequencer idle and loads the default wait counts
`include "char_lcd_nibble_sequencer_macros.svh"

module char_lcd_nibble_sequencer
  import clns_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  clns_req_if.sink              req_i,
  clns_pin_if.source            pin_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [ApbWidth-1:0]   pwdata,
  output logic [ApbWidth-1:0]   prdata,
  output logic                  pready
);

  logic [CfgWidth-1:0] power_up_q, second_wait_q, third_wait_q, settle_q;

  phase_e                phase_q, phase_d;
  logic [7:0]            shift_q, shift_d;
  logic                  sel_q, sel_d;
  logic                  wlatch_q, wlatch_d;
  logic [DelayWidth-1:0] delay_q, delay_d;
  logic [StepWidth-1:0]  step_q, step_d;
  logic                  busy_q, busy_d;

  logic       out_valid_q;
  logic       rs_q, rw_q, en_q, drv_q, idle_q, rej_q;
  logic [3:0] dat_q;
  logic       rs_d, rw_d, en_d, drv_d, idle_d, rej_d;
  logic [3:0] dat_d;

  logic       in_accept;
  logic       cfg_write;
  cfg_reg_e   cfg_sel;
  logic [DelayWidth-1:0] settle_cnt;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = cfg_reg_e'(paddr[PaddrWidth-1:2]);

  assign req_i.ready = !out_valid_q || pin_o.ready;
  assign in_accept   = req_i.valid && req_i.ready;

  // a zero settle count behaves as one
  assign settle_cnt = (DelayWidth'(settle_q) == '0) ? DelayWidth'(1)
                                                    : DelayWidth'(settle_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_up_q    <= PowerUpReset;
      second_wait_q <= SecondWaitReset;
      third_wait_q  <= ThirdWaitReset;
      settle_q      <= SettleReset;
    end else if (cfg_write) begin
      case (cfg_sel)
        RegPowerUp:    power_up_q    <= pwdata[CfgWidth-1:0];
        RegSecondWait: second_wait_q <= pwdata[CfgWidth-1:0];
        RegThirdWait:  third_wait_q  <= pwdata[CfgWidth-1:0];
        RegSettle:     settle_q      <= pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      RegPowerUp:    prdata = ApbWidth'(power_up_q);
      RegSecondWait: prdata = ApbWidth'(second_wait_q);
      RegThirdWait:  prdata = ApbWidth'(third_wait_q);
      RegSettle:     prdata = ApbWidth'(settle_q);
      default:       prdata = '0;
    endcase
  end

  // next state for one beat
  always_comb begin
    logic do_end;
    logic do_start;
    do_end   = 1'b0;
    do_start = 1'b0;
    phase_d  = phase_q;
    shift_d  = shift_q;
    sel_d    = sel_q;
    wlatch_d = wlatch_q;
    delay_d  = delay_q;
    step_d   = step_q;
    busy_d   = busy_q;
    rej_d    = 1'b0;

    if (req_i.op == OpWrite || req_i.op == OpInit) begin
      if (phase_q != PhIdle) begin
        rej_d = 1'b1;
      end else if (req_i.op == OpWrite) begin
        step_d   = StepNone;
        shift_d  = req_i.value;
        sel_d    = req_i.register_select;
        wlatch_d = req_i.wait_busy;
        phase_d  = PhHiSet;
      end else begin
        step_d   = StepPowerUp;
        do_start = 1'b1;
      end
    end else begin
      case (phase_q)
        PhDelay: begin
          if (delay_q != '0) begin
            delay_d = delay_q - DelayWidth'(1);
          end else begin
            shift_d  = WakeNibble;
            sel_d    = 1'b0;
            wlatch_d = 1'b0;
            phase_d  = PhLoSet;
          end
        end
        PhHiSet: phase_d = PhHiEn;
        PhHiEn:  phase_d = PhLoSet;
        PhLoSet: phase_d = PhLoEn;
        PhLoEn: begin
          if (wlatch_q) phase_d = PhBSet;
          else          do_end  = 1'b1;
        end
        PhBSet, PhBGap: begin
          delay_d = settle_cnt;
          phase_d = PhBHold;
        end
        PhBHold: begin
          if (delay_q > DelayWidth'(1)) begin
            delay_d = delay_q - DelayWidth'(1);
          end else begin
            busy_d  = req_i.busy_line;
            phase_d = PhBDrop;
          end
        end
        PhBDrop: phase_d = PhBEn2;
        PhBEn2: begin
          if (busy_q) phase_d = PhBGap;
          else        do_end  = 1'b1;
        end
        default: phase_d = PhIdle;
      endcase
    end

    // finished nibble or byte: leave, or move to the next init step
    if (do_end) begin
      if (step_q == StepNone) begin
        phase_d = PhIdle;
      end else begin
        step_d   = step_q + StepWidth'(1);
        do_start = 1'b1;
      end
    end

    if (do_start) begin
      case (step_d)
        StepPowerUp: begin
          delay_d = DelayWidth'(power_up_q);
          phase_d = PhDelay;
        end
        StepSecondWait: begin
          delay_d = DelayWidth'(second_wait_q);
          phase_d = PhDelay;
        end
        StepThirdWait: begin
          delay_d = DelayWidth'(third_wait_q);
          phase_d = PhDelay;
        end
        StepFourBit: begin
          shift_d  = FourBitNib;
          sel_d    = 1'b0;
          wlatch_d = 1'b1;
          phase_d  = PhLoSet;
        end
        StepFuncSet: begin
          shift_d  = FuncSetCmd;
          sel_d    = 1'b0;
          wlatch_d = 1'b1;
          phase_d  = PhHiSet;
        end
        StepDisplayOn: begin
          shift_d  = DispOnCmd;
          sel_d    = 1'b0;
          wlatch_d = 1'b1;
          phase_d  = PhHiSet;
        end
        default: begin
          step_d  = StepNone;
          phase_d = PhIdle;
        end
      endcase
    end
  end

  // pin levels of the phase just entered
  always_comb begin
    rs_d   = 1'b0;
    rw_d   = 1'b0;
    en_d   = 1'b0;
    dat_d  = 4'h0;
    drv_d  = 1'b1;
    idle_d = 1'b0;
    case (phase_d)
      PhDelay: ;
      PhHiSet, PhHiEn: begin
        rs_d  = sel_d;
        dat_d = shift_d[7:4];
        en_d  = (phase_d == PhHiEn);
      end
      PhLoSet, PhLoEn: begin
        rs_d  = sel_d;
        dat_d = shift_d[3:0];
        en_d  = (phase_d == PhLoEn);
      end
      PhBSet, PhBHold, PhBDrop, PhBEn2, PhBGap: begin
        rw_d  = 1'b1;
        drv_d = 1'b0;
        en_d  = (phase_d == PhBHold) || (phase_d == PhBEn2);
      end
      default: idle_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      shift_q     <= '0;
      sel_q       <= 1'b0;
      wlatch_q    <= 1'b0;
      delay_q     <= '0;
      step_q      <= StepNone;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_q  <= phase_d;
        shift_q  <= shift_d;
        sel_q    <= sel_d;
        wlatch_q <= wlatch_d;
        delay_q  <= delay_d;
        step_q   <= step_d;
        busy_q   <= busy_d;
      end
      if (in_accept)        out_valid_q <= 1'b1;
      else if (pin_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rs_q   <= rs_d;
      rw_q   <= rw_d;
      en_q   <= en_d;
      dat_q  <= dat_d;
      drv_q  <= drv_d;
      idle_q <= idle_d;
      rej_q  <= rej_d;
    end
  end

  assign pin_o.valid       = out_valid_q;
  assign pin_o.rs_pin      = rs_q;
  assign pin_o.rw_pin      = rw_q;
  assign pin_o.enable_pin  = en_q;
  assign pin_o.data_nibble = dat_q;
  assign pin_o.drive_bus   = drv_q;
  assign pin_o.idle        = idle_q;
  assign pin_o.rejected    = rej_q;

  `CLNS_ASSERT_IMPL(a_rej_not_idle, clk_i, rst_ni, out_valid_q && rej_q, !idle_q,
                    "rejected beat reports an idle sequencer")
  `CLNS_ASSERT_IMPL(a_released_reads, clk_i, rst_ni, out_valid_q && !drv_q,
                    rw_q && (dat_q == 4'h0) && !rs_q,
                    "bus released without read mode")
  `CLNS_ASSERT_IMPL(a_init_busy, clk_i, rst_ni, step_q != StepNone, phase_q != PhIdle,
                    "init step pending while idle")
  `CLNS_ASSERT_IMPL(a_hold_count, clk_i, rst_ni, phase_q == PhBHold, delay_q != '0,
                    "settle count empty in enable hold")
  `CLNS_ASSERT_NEXT(a_beat_out, clk_i, rst_ni, in_accept, out_valid_q,
                    "accepted beat produced no result")

endmodule

// ===== tb/sv/char_lcd_nibble_sequencer_tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for the character lcd nibble sequencer: pin beats checked
// against an in-bench phase tracker fed by requests; needs clns_pkg, clns_if.sv and the top level
module char_lcd_nibble_sequencer_tb;
  import clns_pkg::*;

  localparam logic [1:0] OpSpare     = 2'd3;
  localparam int         HoldCycles  = 160;
  localparam int         StallLimit  = 4000;
  localparam int         DrainCycles = 8;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic       rs;
    logic       wb;
    logic       busy;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [3:0] nib;
    logic       drv;
    logic       idl;
    logic       rej;
  } lcd_pins_t;

  typedef struct packed {
    phase_e                ph;
    logic [7:0]            sbyte;
    logic                  sel;
    logic                  wt;
    logic [DelayWidth-1:0] dcnt;
    logic [StepWidth-1:0]  step;
    logic                  bsamp;
  } seq_state_t;

  logic clk;
  logic rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [ApbWidth-1:0]   pwdata;
  logic [ApbWidth-1:0]   prdata;
  logic                  pready;

  clns_req_if req_if ();
  clns_pin_if pin_if ();

  char_lcd_nibble_sequencer u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .pin_o   (pin_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [CfgWidth-1:0] tick_cfg [4];
  seq_state_t          track_seq;
  seq_state_t          plan_seq;
  lcd_req_t            pending_reqs [$];
  lcd_pins_t           pins_expected [$];

  int unsigned send_gap   = 0;
  int unsigned recv_gap   = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done  = 1'b0;
  int unsigned hold_cnt   = 0;
  logic        in_taken   = 1'b0;
  int unsigned stall_cnt  = 0;
  int unsigned err_count  = 0;
  int unsigned pin_beats  = 0;

  // ---------------------------------------------------------------------------
  // phase tracker

  function automatic void load_send(inout seq_state_t s, input logic [7:0] byte_v,
                                    input logic sel, input logic wt, input logic low_only);
    s.sbyte = byte_v;
    s.sel   = sel;
    s.wt    = wt;
    s.ph    = low_only ? PhLoSet : PhHiSet;
  endfunction

  function automatic void load_settle(inout seq_state_t s);
    s.dcnt = tick_cfg[RegSettle];
    if (s.dcnt == '0) s.dcnt = DelayWidth'(1);
    s.ph = PhBHold;
  endfunction

  function automatic void start_step(inout seq_state_t s);
    case (s.step)
      StepPowerUp: begin
        s.dcnt = tick_cfg[RegPowerUp];
        s.ph   = PhDelay;
      end
      StepSecondWait: begin
        s.dcnt = tick_cfg[RegSecondWait];
        s.ph   = PhDelay;
      end
      StepThirdWait: begin
        s.dcnt = tick_cfg[RegThirdWait];
        s.ph   = PhDelay;
      end
      StepFourBit:   load_send(s, FourBitNib, 1'b0, 1'b1, 1'b1);
      StepFuncSet:   load_send(s, FuncSetCmd, 1'b0, 1'b1, 1'b0);
      StepDisplayOn: load_send(s, DispOnCmd, 1'b0, 1'b1, 1'b0);
      default: begin
        s.step = StepNone;
        s.ph   = PhIdle;
      end
    endcase
  endfunction

  function automatic void end_send(inout seq_state_t s);
    if (s.step == StepNone) begin
      s.ph = PhIdle;
    end else begin
      s.step = s.step + 1'b1;
      start_step(s);
    end
  endfunction

  function automatic lcd_pins_t lcd_advance(inout seq_state_t s, input lcd_req_t rq);
    lcd_pins_t p;
    logic      rej;
    rej = 1'b0;
    if (rq.op == OpWrite || rq.op == OpInit) begin
      if (s.ph != PhIdle) begin
        rej = 1'b1;
      end else if (rq.op == OpWrite) begin
        s.step = StepNone;
        load_send(s, rq.value, rq.rs, rq.wb, 1'b0);
      end else begin
        s.step = StepPowerUp;
        start_step(s);
      end
    end else begin
      case (s.ph)
        PhDelay: begin
          if (s.dcnt != '0) s.dcnt = s.dcnt - 1'b1;
          else load_send(s, WakeNibble, 1'b0, 1'b0, 1'b1);
        end
        PhHiSet: s.ph = PhHiEn;
        PhHiEn:  s.ph = PhLoSet;
        PhLoSet: s.ph = PhLoEn;
        PhLoEn: begin
          if (s.wt) s.ph = PhBSet;
          else end_send(s);
        end
        PhBSet:  load_settle(s);
        PhBHold: begin
          if (s.dcnt > 1) begin
            s.dcnt = s.dcnt - 1'b1;
          end else begin
            s.bsamp = rq.busy;
            s.ph    = PhBDrop;
          end
        end
        PhBDrop: s.ph = PhBEn2;
        PhBEn2: begin
          if (s.bsamp) s.ph = PhBGap;
          else end_send(s);
        end
        PhBGap:  load_settle(s);
        default: s.ph = PhIdle;
      endcase
    end

    p     = '0;
    p.drv = 1'b1;
    case (s.ph)
      PhDelay: ;
      PhHiSet, PhHiEn: begin
        p.rs  = s.sel;
        p.nib = s.sbyte[7:4];
        p.en  = (s.ph == PhHiEn);
      end
      PhLoSet, PhLoEn: begin
        p.rs  = s.sel;
        p.nib = s.sbyte[3:0];
        p.en  = (s.ph == PhLoEn);
      end
      PhBSet, PhBHold, PhBDrop, PhBEn2, PhBGap: begin
        p.rw  = 1'b1;
        p.drv = 1'b0;
        p.en  = (s.ph == PhBHold || s.ph == PhBEn2);
      end
      default: p.idl = 1'b1;
    endcase
    p.rej = rej;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus planning

  function automatic void add_req(logic [1:0] op, logic [7:0] value, logic rs,
                                  logic wb, logic busy);
    lcd_req_t r;
    r = '{op: op, value: value, rs: rs, wb: wb, busy: busy};
    pending_reqs.push_back(r);
    void'(lcd_advance(plan_seq, r));
  endfunction

  // finish whatever sequence is running so the next setting starts from idle
  function automatic void run_to_idle();
    while (plan_seq.ph != PhIdle)
      add_req(OpTick, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
  endfunction

  function automatic void plan_random(int unsigned n_items);
    logic [1:0]  op;
    int unsigned pick;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (plan_seq.ph == PhIdle) begin
        if (pick < 55) op = OpWrite;
        else if (pick < 70) op = OpInit;
        else if (pick < 75) op = OpSpare;
        else op = OpTick;
      end else begin
        if (pick < 4) op = OpWrite;
        else if (pick < 7) op = OpInit;
        else if (pick < 10) op = OpSpare;
        else op = OpTick;
      end
      add_req(op, 8'($urandom), 1'($urandom), 1'($urandom), $urandom_range(99) < 35);
    end
    run_to_idle();
  endfunction

  // ---------------------------------------------------------------------------
  // sequencing helpers

  task automatic cfg_write(cfg_reg_e idx, logic [CfgWidth-1:0] value);
    logic [ApbWidth-1:0] word;
    word = $urandom;
    word[CfgWidth-1:0] = value;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = word;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    tick_cfg[idx] = value;
  endtask

  task automatic set_waits(logic [CfgWidth-1:0] pwr, logic [CfgWidth-1:0] second,
                           logic [CfgWidth-1:0] third, logic [CfgWidth-1:0] settle);
    cfg_write(RegPowerUp, pwr);
    cfg_write(RegSecondWait, second);
    cfg_write(RegThirdWait, third);
    cfg_write(RegSettle, settle);
  endtask

  task automatic set_gaps(int unsigned s_gap, int unsigned r_gap);
    @(posedge clk);
    send_gap <= s_gap;
    recv_gap <= r_gap;
  endtask

  // wait until every queued beat has been sent and every pin beat has come out
  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || pins_expected.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // clock, driver, receiver, monitor

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || in_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap) begin
        {req_if.op, req_if.value, req_if.register_select, req_if.wait_busy,
         req_if.busy_line} <= pending_reqs.pop_front();
        req_if.valid <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pin_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      pin_if.ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt  = HoldCycles - 1;
      pin_if.ready <= 1'b0;
    end else begin
      pin_if.ready <= ($urandom_range(99) >= recv_gap);
    end
  end

  always @(posedge clk) begin
    lcd_pins_t got;
    lcd_pins_t want;
    lcd_req_t  rq;
    logic      out_taken;
    if (rst_n) begin
      in_taken  = req_if.valid && req_if.ready;
      out_taken = pin_if.valid && pin_if.ready;
      if (out_taken) begin
        got = '{rs: pin_if.rs_pin, rw: pin_if.rw_pin, en: pin_if.enable_pin,
                nib: pin_if.data_nibble, drv: pin_if.drive_bus, idl: pin_if.idle,
                rej: pin_if.rejected};
        if (pins_expected.size() == 0) begin
          if (err_count < 10)
            $display("pin beat %0d arrived with nothing expected: %p", pin_beats, got);
          err_count++;
        end else begin
          want = pins_expected.pop_front();
          if (got !== want) begin
            if (err_count < 10) begin
              $display("pin beat %0d: expected rs=%b rw=%b en=%b nib=%h drv=%b idle=%b rej=%b",
                       pin_beats, want.rs, want.rw, want.en, want.nib, want.drv, want.idl,
                       want.rej);
              $display("pin beat %0d:      got rs=%b rw=%b en=%b nib=%h drv=%b idle=%b rej=%b",
                       pin_beats, got.rs, got.rw, got.en, got.nib, got.drv, got.idl, got.rej);
            end
            err_count++;
          end
        end
        pin_beats++;
      end
      if (in_taken) begin
        rq = '{op: req_if.op, value: req_if.value, rs: req_if.register_select,
               wb: req_if.wait_busy, busy: req_if.busy_line};
        pins_expected.push_back(lcd_advance(track_seq, rq));
      end
      if (in_taken || out_taken) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= StallLimit) begin
          $display("no beat moved for %0d cycles", stall_cnt);
          $display("char_lcd_nibble_sequencer_tb: errors");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence

  initial begin
    int i;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_if.valid           = 1'b0;
    req_if.op              = OpTick;
    req_if.value           = '0;
    req_if.register_select = 1'b0;
    req_if.wait_busy       = 1'b0;
    req_if.busy_line       = 1'b0;
    pin_if.ready           = 1'b0;
    tick_cfg[RegPowerUp]    = PowerUpReset;
    tick_cfg[RegSecondWait] = SecondWaitReset;
    tick_cfg[RegThirdWait]  = ThirdWaitReset;
    tick_cfg[RegSettle]     = SettleReset;
    track_seq = '0;
    plan_seq  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, with the reset wait counts
    set_gaps(23, 78);
    add_req(OpTick, 8'hff, 1'b1, 1'b1, 1'b1);
    add_req(OpWrite, 8'hff, 1'b1, 1'b0, 1'b0);
    add_req(OpTick, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(OpSpare, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(OpTick, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(OpTick, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(OpWrite, 8'h00, 1'b0, 1'b1, 1'b1);
    // requests while busy get refused
    add_req(OpWrite, 8'h5a, 1'b1, 1'b0, 1'b0);
    add_req(OpInit, 8'ha5, 1'b0, 1'b1, 1'b0);
    // busy seen set on the first poll, clear on the second
    for (i = 0; i < 12; i++)
      add_req(OpTick, 8'h00, 1'b0, 1'b0, i < 6);
    run_to_idle();
    drain();

    // shortest waits, minimum settle
    set_waits('0, '0, '0, 20'd1);
    set_gaps(23, 78);
    plan_random(600);
    drain();

    // zero settle behaves like one
    set_waits(20'($urandom_range(1, 12)), 20'($urandom_range(1, 12)),
              20'($urandom_range(1, 12)), '0);
    set_gaps(78, 23);
    plan_random(600);
    drain();

    // largest counts: only plain writes so no wait is ever run
    set_waits('1, '1, '1, '1);
    for (i = 0; i < 3; i++) begin
      add_req(OpWrite, 8'($urandom), 1'($urandom), 1'b0, 1'($urandom));
      run_to_idle();
    end
    drain();

    // no idling, with one long receiver hold at the start
    set_waits(20'($urandom_range(0, 20)), 20'($urandom_range(0, 20)),
              20'($urandom_range(0, 20)), 20'($urandom_range(2, 6)));
    set_gaps(0, 0);
    hold_armed <= 1'b1;
    plan_random(450);
    drain();

    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("char_lcd_nibble_sequencer_tb: clean");
    end else begin
      $display("char_lcd_nibble_sequencer_tb: errors");
    end
    $finish;
  end

endmodule
